// ===== src/rau_pkg.sv =====
package rau_pkg;

  localparam logic signed [31:0] VALUE_LIMIT = 32'sd10000000;

  localparam logic [3:0] F_ADD = 4'd0;
  localparam logic [3:0] F_SUB = 4'd1;
  localparam logic [3:0] F_MUL = 4'd2;
  localparam logic [3:0] F_DIV = 4'd3;
  localparam logic [3:0] F_MOD = 4'd4;
  localparam logic [3:0] F_LT  = 4'd5;
  localparam logic [3:0] F_GT  = 4'd6;
  localparam logic [3:0] F_LE  = 4'd7;
  localparam logic [3:0] F_GE  = 4'd8;
  localparam logic [3:0] F_EQ  = 4'd9;
  localparam logic [3:0] F_RED = 4'd10;
  localparam logic [3:0] F_NAT = 4'd11;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZDEN = 2'd1;
  localparam logic [1:0] ST_LIM  = 2'd2;
  localparam logic [1:0] ST_DZ   = 2'd3;

  typedef struct packed {
    logic start;
    logic sgn;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_rsp_t;

endpackage

// ===== src/rau_div.sv =====
module rau_div (
  input  logic               clk,
  input  logic               rst,
  input  rau_pkg::div_req_t  req,
  input  logic [31:0]        dividend,
  input  logic [31:0]        divisor,
  output rau_pkg::div_rsp_t  rsp,
  output logic [31:0]        quot,
  output logic [31:0]        rem
);

  logic        busy;
  logic        done;
  logic [4:0]  cnt;
  logic [31:0] acc;
  logic [31:0] quo;
  logic [31:0] dvs;
  logic        neg_q;
  logic        neg_r;
  logic [32:0] sh;
  logic [32:0] diff;
  logic        qbit;

  assign sh   = {acc, quo[31]};
  assign diff = sh - {1'b0, dvs};
  assign qbit = !diff[32];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        cnt   <= '0;
        acc   <= '0;
        quo   <= (req.sgn && dividend[31]) ? -dividend : dividend;
        dvs   <= (req.sgn && divisor[31]) ? -divisor : divisor;
        neg_q <= req.sgn && (dividend[31] ^ divisor[31]);
        neg_r <= req.sgn && dividend[31];
      end else if (busy) begin
        acc <= qbit ? diff[31:0] : sh[31:0];
        quo <= {quo[30:0], qbit};
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quot     = neg_q ? -quo : quo;
  assign rem      = neg_r ? -acc : acc;
  assign rsp.busy = busy;
  assign rsp.done = done;

endmodule

// ===== src/rational_arithmetic_unit.sv =====
// Rational arithmetic on two signed 32-bit fractions, one item at a time. The
// operations share one 32x32 multiplier and one radix-2 divider, which gives a
// quotient and a remainder per pass. Mul, div and compares use the multiplier;
// mod uses both and is_natural only the divider. Reduce, eq, add and sub run
// Euclid's gcd, one divider pass per remainder step; le and ge run it only when
// the strict compare fails, and eq, le and ge then reduce both fractions.
// A finished result waits in the output register while the next item is taken.
module rational_arithmetic_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [127:0]  s_axis_tdata,  // a_num, a_den, b_num, b_den
  input  logic [3:0]    s_axis_tuser,  // func
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [71:0]   m_axis_tdata   // res_num, res_den, truth, status, zero fill
);

  typedef enum logic [21:0] {
    S_IDLE  = 22'h000001,
    S_CHK   = 22'h000002,
    S_M1    = 22'h000004,
    S_M2    = 22'h000008,
    S_M3    = 22'h000010,
    S_MODD  = 22'h000020,
    S_CMP   = 22'h000040,
    S_RED   = 22'h000080,
    S_RDIV1 = 22'h000100,
    S_RDIV2 = 22'h000200,
    S_RNEG  = 22'h000400,
    S_GCD   = 22'h000800,
    S_GDIV  = 22'h001000,
    S_L1    = 22'h002000,
    S_L2    = 22'h004000,
    S_L3    = 22'h008000,
    S_L4    = 22'h010000,
    S_L5    = 22'h020000,
    S_L6    = 22'h040000,
    S_L7    = 22'h080000,
    S_NATD  = 22'h100000,
    S_DONE  = 22'h200000
  } state_t;

  state_t state;

  logic [3:0]         fn;
  logic signed [31:0] an, ad, bn, bd;
  logic signed [31:0] gx, gy, g, rx, ry, ea_n, ea_d;
  logic [31:0]        gxm, gym;
  logic signed [31:0] p, q, l, t1, rn, rd;
  logic               truth_r, frac_r, phase, dbusy;
  logic [1:0]         st_r;

  logic signed [31:0] mul_a, mul_b, mul_w;
  logic [31:0]        dvd, dvs;
  logic [31:0]        dquot, drem;
  rau_pkg::div_req_t  div_req;
  rau_pkg::div_rsp_t  div_rsp;
  logic               div_state;

  logic               st1, flip, lt_b, gt_b, cmp_bit, is_addsub;
  logic signed [31:0] rxn, ryn;
  logic               beyond;
  logic [1:0]         st_f;
  state_t             gcd_ret;

  assign s_axis_tready = (state == S_IDLE);
  assign mul_w = mul_a * mul_b;

  always_comb begin
    mul_a = an;
    mul_b = bn;
    unique case (state)
      S_M1: begin
        unique case (fn)
          rau_pkg::F_MUL: begin mul_a = an; mul_b = bn; end
          rau_pkg::F_MOD: begin mul_a = ad; mul_b = bn; end
          default:        begin mul_a = an; mul_b = bd; end
        endcase
      end
      S_M2: begin
        unique case (fn)
          rau_pkg::F_MUL, rau_pkg::F_MOD: begin mul_a = ad; mul_b = bd; end
          default:                        begin mul_a = ad; mul_b = bn; end
        endcase
      end
      S_M3: begin mul_a = bd; mul_b = an; end
      S_L1: begin mul_a = ad; mul_b = bd; end
      S_L4: begin mul_a = t1; mul_b = an; end
      S_L6: begin mul_a = q;  mul_b = bn; end
      default: begin mul_a = an; mul_b = bn; end
    endcase
  end

  always_comb begin
    dvd         = q;
    dvs         = p;
    div_req.sgn = 1'b1;
    div_state   = 1'b1;
    unique case (state)
      S_MODD:  begin dvd = q;   dvs = p;  end
      S_NATD:  begin dvd = an;  dvs = ad; end
      S_RDIV1: begin dvd = rx;  dvs = g;  end
      S_RDIV2: begin dvd = ry;  dvs = g;  end
      S_GDIV:  begin dvd = gxm; dvs = gym; div_req.sgn = 1'b0; end
      S_L2:    begin dvd = p;   dvs = g;  end
      S_L3:    begin dvd = l;   dvs = ad; end
      S_L5:    begin dvd = l;   dvs = bd; end
      default: div_state = 1'b0;
    endcase
    div_req.start = div_state && !dbusy;
  end

  rau_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .dividend (dvd),
    .divisor  (dvs),
    .rsp      (div_rsp),
    .quot     (dquot),
    .rem      (drem)
  );

  always_comb begin
    st1 = (fn <= rau_pkg::F_NAT) &&
          ((ad == 0) || ((fn <= rau_pkg::F_EQ) && (bd == 0)));
    flip = ad[31] ^ bd[31];
    lt_b = flip ? (p > q) : (p < q);
    gt_b = flip ? (p < q) : (p > q);
    cmp_bit = ((fn == rau_pkg::F_LT) || (fn == rau_pkg::F_LE)) ? lt_b : gt_b;
    is_addsub = (fn == rau_pkg::F_ADD) || (fn == rau_pkg::F_SUB);
    gcd_ret = is_addsub ? S_L1 : S_RDIV1;
    rxn = ry[31] ? -rx : rx;
    ryn = ry[31] ? -ry : ry;
    beyond = (rn > rau_pkg::VALUE_LIMIT) || (rn < -rau_pkg::VALUE_LIMIT) ||
             (rd > rau_pkg::VALUE_LIMIT) || (rd < -rau_pkg::VALUE_LIMIT);
    st_f = st_r;
    if (frac_r && (st_r == rau_pkg::ST_OK)) begin
      if (rd == 0) st_f = rau_pkg::ST_ZDEN;
      else if (beyond) st_f = rau_pkg::ST_LIM;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      dbusy         <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (div_req.start) dbusy <= 1'b1;
      else if (div_rsp.done) dbusy <= 1'b0;
      if (m_axis_tvalid && m_axis_tready && (state != S_DONE)) m_axis_tvalid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            fn      <= s_axis_tuser;
            an      <= s_axis_tdata[31:0];
            ad      <= s_axis_tdata[63:32];
            bn      <= s_axis_tdata[95:64];
            bd      <= s_axis_tdata[127:96];
            truth_r <= 1'b0;
            frac_r  <= 1'b0;
            st_r    <= rau_pkg::ST_OK;
            rn      <= '0;
            rd      <= 32'sd1;
            state   <= S_CHK;
          end
        end
        S_CHK: begin
          if (st1) begin
            st_r  <= rau_pkg::ST_ZDEN;
            state <= S_DONE;
          end else begin
            unique case (fn)
              rau_pkg::F_ADD, rau_pkg::F_SUB: begin
                gx <= ad; gy <= bd; state <= S_GCD;
              end
              rau_pkg::F_DIV: begin
                if (bn == 0) begin
                  st_r <= rau_pkg::ST_DZ; state <= S_DONE;
                end else state <= S_M1;
              end
              rau_pkg::F_MUL, rau_pkg::F_MOD, rau_pkg::F_LT, rau_pkg::F_GT,
              rau_pkg::F_LE, rau_pkg::F_GE: state <= S_M1;
              rau_pkg::F_EQ, rau_pkg::F_RED: begin
                rx <= an; ry <= ad; phase <= 1'b0; state <= S_RED;
              end
              rau_pkg::F_NAT: state <= S_NATD;
              default: state <= S_DONE;
            endcase
          end
        end
        S_M1: begin
          if ((fn == rau_pkg::F_MUL) || (fn == rau_pkg::F_DIV)) rn <= mul_w;
          else p <= mul_w;
          state <= S_M2;
        end
        S_M2: begin
          unique case (fn)
            rau_pkg::F_MUL, rau_pkg::F_DIV: begin
              rd <= mul_w; frac_r <= 1'b1; state <= S_DONE;
            end
            rau_pkg::F_MOD: begin rd <= mul_w; state <= S_M3; end
            default: begin q <= mul_w; state <= S_CMP; end
          endcase
        end
        S_M3: begin
          q <= mul_w;
          if ((bn == 0) || (p == 0)) begin
            st_r <= rau_pkg::ST_DZ; state <= S_DONE;
          end else state <= S_MODD;
        end
        S_MODD: begin
          if (div_rsp.done) begin
            rn <= drem; frac_r <= 1'b1; state <= S_DONE;
          end
        end
        S_CMP: begin
          if ((fn == rau_pkg::F_LT) || (fn == rau_pkg::F_GT) || cmp_bit) begin
            truth_r <= cmp_bit; state <= S_DONE;
          end else begin
            rx <= an; ry <= ad; phase <= 1'b0; state <= S_RED;
          end
        end
        S_RED: begin
          if (rx == 0) begin
            ry <= 32'sd1; state <= S_RNEG;
          end else begin
            gx <= rx; gy <= ry; state <= S_GCD;
          end
        end
        S_GCD: begin
          if (gx == 0) begin
            g <= (gy > 0) ? gy : 32'sd1; state <= gcd_ret;
          end else if (gy == 0) begin
            g <= (gx > 0) ? gx : 32'sd1; state <= gcd_ret;
          end else begin
            gxm   <= gx[31] ? -gx : gx;
            gym   <= gy[31] ? -gy : gy;
            state <= S_GDIV;
          end
        end
        S_GDIV: begin
          if (div_rsp.done) begin
            if (drem == 0) begin
              g <= gym; state <= gcd_ret;
            end else begin
              gxm <= gym; gym <= drem;
            end
          end
        end
        S_RDIV1: if (div_rsp.done) begin rx <= dquot; state <= S_RDIV2; end
        S_RDIV2: if (div_rsp.done) begin ry <= dquot; state <= S_RNEG; end
        S_RNEG: begin
          if (fn == rau_pkg::F_RED) begin
            rn <= rxn; rd <= ryn; frac_r <= 1'b1; state <= S_DONE;
          end else if (!phase) begin
            ea_n <= rxn; ea_d <= ryn;
            rx <= bn; ry <= bd; phase <= 1'b1; state <= S_RED;
          end else begin
            truth_r <= (ea_n == rxn) && (ea_d == ryn); state <= S_DONE;
          end
        end
        S_L1: begin p <= mul_w; state <= S_L2; end
        S_L2: if (div_rsp.done) begin
          l <= dquot[31] ? '0 : dquot; state <= S_L3;
        end
        S_L3: if (div_rsp.done) begin t1 <= dquot; state <= S_L4; end
        S_L4: begin t1 <= mul_w; state <= S_L5; end
        S_L5: if (div_rsp.done) begin q <= dquot; state <= S_L6; end
        S_L6: begin q <= mul_w; state <= S_L7; end
        S_L7: begin
          rn     <= (fn == rau_pkg::F_ADD) ? t1 + q : t1 - q;
          rd     <= l;
          frac_r <= 1'b1;
          state  <= S_DONE;
        end
        S_NATD: begin
          if (div_rsp.done) begin
            truth_r <= (drem == 0) && ((ad[31] ? (an < 0) : (an > 0)) || (an == 0));
            state   <= S_DONE;
          end
        end
        S_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid        <= 1'b1;
            m_axis_tdata[71:67]  <= '0;
            m_axis_tdata[66:65]  <= st_f;
            if ((st_f != rau_pkg::ST_OK) || !frac_r) begin
              m_axis_tdata[31:0]  <= '0;
              m_axis_tdata[63:32] <= 32'd1;
            end else begin
              m_axis_tdata[31:0]  <= rn;
              m_axis_tdata[63:32] <= rd;
            end
            m_axis_tdata[64] <= (st_f == rau_pkg::ST_OK) && truth_r;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("block ready right after accepting an item");

  a_refusal_fields: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tdata[66:65] != rau_pkg::ST_OK)) |->
    ((m_axis_tdata[31:0] == 32'd0) && (m_axis_tdata[63:32] == 32'd1) &&
     !m_axis_tdata[64]))
    else $error("refused result carries nonzero fields");

  a_div_done_owned: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (dbusy && div_state))
    else $error("divider finished outside a divide step");

endmodule
